>>> src/dced_pkg.sv
// Shared types, constants and helpers of the directional-change event detector.
package dced_pkg;

  localparam int MAX_RECORDS = 16;
  localparam int CNT_W       = $clog2(MAX_RECORDS);
  localparam int Q_FRAC      = 28;
  localparam int DIV_STEPS   = 32 + Q_FRAC;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam logic [2:0] REG_EVENT_THRESHOLD  = 3'd0;
  localparam logic [2:0] REG_VOLUME_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_INITIAL_PRICE    = 3'd2;
  localparam logic [2:0] REG_INITIAL_TIME     = 3'd3;
  localparam logic [2:0] REG_WINDOW_START     = 3'd4;
  localparam logic [2:0] REG_WINDOW_END       = 3'd5;

  typedef struct packed {
    logic [31:0] trade_price;
    logic [31:0] trade_volume;
    logic        is_buy;
    logic [47:0] trade_time;
  } in_t;

  typedef struct packed {
    logic [47:0]        event_time;
    logic [31:0]        event_price;
    logic [31:0]        high_price;
    logic [31:0]        low_price;
    logic signed [31:0] event_move;
    logic signed [31:0] top_excursion;
    logic signed [31:0] bottom_excursion;
    logic [47:0]        duration;
    logic [31:0]        event_volume;
    logic [31:0]        trade_count;
    logic               last_of_run;
  } out_t;

  // Operands of one ratio (p - n) / d.
  typedef struct packed {
    logic [31:0] p;
    logic [31:0] n;
    logic [31:0] d;
  } div_req_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

>>> src/dced_div.sv
// Bit-serial signed ratio unit: saturating (p - n) * 2^28 / d.
module dced_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  dced_pkg::div_req_t req,
  output logic               done,
  output logic signed [31:0] quo
);

  logic                          busy;
  logic                          fin;
  logic [dced_pkg::STEP_W-1:0]   cnt;
  logic [dced_pkg::DIV_STEPS-1:0] dvd;
  logic [dced_pkg::DIV_STEPS-1:0] q;
  logic [31:0]                   rem;
  logic [31:0]                   dr;
  logic                          neg;
  logic                          req_neg;
  logic [31:0]                   mag;
  logic [32:0]                   rs;
  logic                          ge;
  logic [32:0]                   diff;

  assign req_neg = req.p < req.n;
  assign mag     = req_neg ? (req.n - req.p) : (req.p - req.n);
  assign rs      = {rem, dvd[dced_pkg::DIV_STEPS-1]};
  assign ge      = rs >= {1'b0, dr};
  assign diff    = rs - {1'b0, dr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        fin <= 1'b0;
        neg <= req_neg;
        if (mag == 32'd0) begin
          quo  <= 32'sd0;
          done <= 1'b1;
        end else if (req.d == 32'd0) begin
          quo  <= req_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
          busy <= 1'b1;
          cnt  <= dced_pkg::STEP_W'(dced_pkg::DIV_STEPS - 1);
          dvd  <= {mag, {dced_pkg::Q_FRAC{1'b0}}};
          rem  <= 32'd0;
          q    <= '0;
          dr   <= req.d;
        end
      end else if (busy) begin
        done <= 1'b0;
        fin  <= (cnt == '0);
        rem  <= ge ? diff[31:0] : rs[31:0];
        q    <= {q[dced_pkg::DIV_STEPS-2:0], ge};
        dvd  <= {dvd[dced_pkg::DIV_STEPS-2:0], 1'b0};
        cnt  <= cnt - 1'b1;
        if (cnt == '0)
          busy <= 1'b0;
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        if (q[dced_pkg::DIV_STEPS-1:31] != '0)
          quo <= neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else if (neg)
          quo <= $signed(~{1'b0, q[30:0]} + 32'd1);
        else
          quo <= $signed({1'b0, q[30:0]});
      end else begin
        done <= 1'b0;
        fin  <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy && !fin) else $error("ratio unit restarted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("ratio unit done held");
  a_fin_done: assert property (@(posedge clk) disable iff (rst)
    fin |=> done) else $error("ratio unit lost its result");
`endif

endmodule

>>> src/directional_change_event_detector.sv
// Top level of the directional-change event detector: sequencer and event state.
//
//  channel | signals                     | direction | transaction when
//  --------+-----------------------------+-----------+-----------------------------
//  in      | in_valid, in_stall, in_data | into      | in_valid && !in_stall
//  out     | out_valid, out_stall, out_data | out of | out_valid && !out_stall
//  cfg     | cfg_we, cfg_index, cfg_data | into      | cfg_we
//
//  One tick at a time. A quiet tick inside the window takes two ratios, or three
//  when it moves the maximum or minimum; each ratio is bit-serial on one shared
//  divider, which settles a zero numerator or divisor without iterating. A
//  closing tick adds one more ratio and the final record; each overshoot record
//  adds three ratios and its handshake. Ticks outside the window take no ratio.
//  Reset (rst, synchronous) loads the register defaults and the event state.
//  in_stall is high whenever a tick is in work; a stalled result holds the
//  sequencer in its emit step only.
module directional_change_event_detector (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  dced_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output dced_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [47:0]     cfg_data
);

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_PRE     = 18'h00002,
    S_DRISE   = 18'h00004,
    S_DFALL   = 18'h00008,
    S_DDOWN   = 18'h00010,
    S_DUP     = 18'h00020,
    S_TEST    = 18'h00040,
    S_MULEP   = 18'h00080,
    S_SETEP   = 18'h00100,
    S_DMV     = 18'h00200,
    S_LOOP    = 18'h00400,
    S_EMITOS  = 18'h00800,
    S_MULNX   = 18'h01000,
    S_SETNX   = 18'h02000,
    S_ORISE   = 18'h04000,
    S_OFALL   = 18'h08000,
    S_OMV     = 18'h10000,
    S_EMITFIN = 18'h20000
  } state_t;

  localparam logic signed [34:0] ONE = 35'sd268435456;

  state_t state, state_next;

  // configuration
  logic [27:0] dl;
  logic [31:0] vth;
  logic [47:0] win_start;
  logic [47:0] win_end;

  // event state
  logic [31:0]        fp, prior, buy_acc, sell_acc, start_p, max_p, min_p;
  logic signed [31:0] rise, fall, down, up, mv;
  logic [47:0]        start_time;
  logic [31:0]        vol_sum, tick_cnt;
  logic               past;

  // per-tick work registers
  dced_pkg::in_t           tick;
  logic                    rising;
  logic signed [34:0]      rem;
  logic [47:0]             dur;
  logic [31:0]             ep;
  logic [dced_pkg::CNT_W-1:0] n;
  logic [64:0]             prod;
  logic                    fac_nonpos;

  // shared ratio unit
  logic                    launch;
  logic                    div_done;
  logic signed [31:0]      div_q;
  dced_pkg::div_req_t      div_req;

  logic               accept, win_skip, win_late, max_up, min_up;
  logic               fire, loop_go, emit_ok, emit_fire;
  logic [31:0]        acc_sum, fp_new;
  logic               acc_hit;
  logic signed [33:0] sum_top, sum_bot;
  logic signed [34:0] factor;
  logic [31:0]        mul_price;
  logic [31:0]        scaled;
  logic signed [34:0] dl_s;
  logic signed [31:0] top_cap, bot_cap;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign emit_ok   = !out_valid || !out_stall;
  assign emit_fire = ((state == S_EMITOS) || (state == S_EMITFIN)) && emit_ok;
  assign dl_s      = $signed({7'd0, dl});

  // Window and volume filter of the latched tick.
  assign win_late = tick.trade_time > win_end;
  assign win_skip = past || (tick.trade_time < win_start) || win_late;
  assign acc_sum  = dced_pkg::sat_add(tick.is_buy ? buy_acc : sell_acc, tick.trade_volume);
  assign acc_hit  = acc_sum > vth;

  always_comb begin
    fp_new = fp;
    if (acc_hit) begin
      if (tick.is_buy && (tick.trade_price < fp)) fp_new = tick.trade_price;
      if (!tick.is_buy && (tick.trade_price > fp)) fp_new = tick.trade_price;
    end
  end

  assign max_up = fp_new > max_p;
  assign min_up = !max_up && (fp_new < min_p);

  assign sum_top = 34'(rise) + 34'(down);
  assign sum_bot = 34'(fall) + 34'(up);
  assign fire    = (35'(sum_top) >= dl_s) || (35'(sum_bot) >= dl_s);
  assign loop_go = (rem >= (dl_s <<< 1)) && (n < dced_pkg::CNT_W'(dced_pkg::MAX_RECORDS - 1));

  assign top_cap = (35'(rise) < dl_s) ? rise : $signed({4'd0, dl});
  assign bot_cap = (35'(fall) < dl_s) ? fall : $signed({4'd0, dl});

  // Scale factor and price for the single multiply.
  always_comb begin
    if (state == S_MULEP) begin
      mul_price = rising ? min_p : max_p;
      factor    = rising ? (ONE + dl_s - 35'(fall)) : (ONE - dl_s + 35'(rise));
    end else begin
      mul_price = ep;
      factor    = rising ? (ONE + dl_s) : (ONE - dl_s);
    end
  end

  assign scaled = fac_nonpos ? 32'd0 :
                  (prod[64:60] != '0) ? 32'hFFFF_FFFF : prod[59:28];

  // Ratio operands per step.
  always_comb begin
    unique case (state)
      S_DRISE, S_ORISE: div_req = '{p: max_p,   n: start_p, d: start_p};
      S_DFALL, S_OFALL: div_req = '{p: start_p, n: min_p,   d: start_p};
      S_DDOWN:          div_req = '{p: max_p,   n: fp,      d: max_p};
      S_DUP:            div_req = '{p: fp,      n: min_p,   d: min_p};
      default:          div_req = '{p: start_p, n: ep,      d: start_p};
    endcase
  end

  dced_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (launch),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (accept) state_next = S_PRE;
      S_PRE:     state_next = win_skip ? S_IDLE : max_up ? S_DRISE : min_up ? S_DFALL : S_DDOWN;
      S_DRISE:   if (div_done) state_next = S_DDOWN;
      S_DFALL:   if (div_done) state_next = S_DDOWN;
      S_DDOWN:   if (div_done) state_next = S_DUP;
      S_DUP:     if (div_done) state_next = S_TEST;
      S_TEST:    state_next = fire ? S_MULEP : S_IDLE;
      S_MULEP:   state_next = S_SETEP;
      S_SETEP:   state_next = S_DMV;
      S_DMV:     if (div_done) state_next = S_LOOP;
      S_LOOP:    state_next = loop_go ? S_EMITOS : S_EMITFIN;
      S_EMITOS:  if (emit_ok) state_next = S_MULNX;
      S_MULNX:   state_next = S_SETNX;
      S_SETNX:   state_next = S_ORISE;
      S_ORISE:   if (div_done) state_next = S_OFALL;
      S_OFALL:   if (div_done) state_next = S_OMV;
      S_OMV:     if (div_done) state_next = S_LOOP;
      S_EMITFIN: if (emit_ok) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  logic next_is_div;
  assign next_is_div = (state_next == S_DRISE) || (state_next == S_DFALL) ||
                       (state_next == S_DDOWN) || (state_next == S_DUP) ||
                       (state_next == S_DMV) || (state_next == S_ORISE) ||
                       (state_next == S_OFALL) || (state_next == S_OMV);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      launch     <= 1'b0;
      out_valid  <= 1'b0;
      dl         <= 28'd2684355;
      vth        <= 32'd2560;
      win_start  <= 48'd0;
      win_end    <= 48'hFFFF_FFFF_FFFF;
      fp         <= 32'd256;
      prior      <= 32'd256;
      start_p    <= 32'd256;
      max_p      <= 32'd256;
      min_p      <= 32'd256;
      buy_acc    <= 32'd0;
      sell_acc   <= 32'd0;
      rise       <= 32'sd0;
      fall       <= 32'sd0;
      start_time <= 48'd0;
      vol_sum    <= 32'd0;
      tick_cnt   <= 32'd0;
      past       <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= next_is_div && (state_next != state);
      // Drop the record once taken, unless a new one replaces it.
      if (out_valid && !out_stall && !emit_fire) out_valid <= 1'b0;

      // Register writes; loading a start price or time also loads the event.
      if (cfg_we) begin
        unique case (cfg_index)
          dced_pkg::REG_EVENT_THRESHOLD:  dl  <= cfg_data[27:0];
          dced_pkg::REG_VOLUME_THRESHOLD: vth <= cfg_data[31:0];
          dced_pkg::REG_INITIAL_PRICE: begin
            fp         <= cfg_data[31:0];
            prior      <= cfg_data[31:0];
            start_p    <= cfg_data[31:0];
            max_p      <= cfg_data[31:0];
            min_p      <= cfg_data[31:0];
          end
          dced_pkg::REG_INITIAL_TIME: start_time <= cfg_data;
          dced_pkg::REG_WINDOW_START: win_start <= cfg_data;
          dced_pkg::REG_WINDOW_END:   win_end   <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: if (accept) tick <= in_data;
        S_PRE: begin
          if (win_skip) begin
            if (!past && !(tick.trade_time < win_start) && win_late) past <= 1'b1;
          end else begin
            if (tick.is_buy) buy_acc <= acc_hit ? 32'd0 : acc_sum;
            else sell_acc <= acc_hit ? 32'd0 : acc_sum;
            fp       <= fp_new;
            rising   <= fp_new > prior;
            prior    <= fp_new;
            if (max_up) max_p <= fp_new;
            if (min_up) min_p <= fp_new;
            tick_cnt <= dced_pkg::sat_add(tick_cnt, 32'd1);
          end
        end
        S_DRISE, S_ORISE: if (div_done) rise <= div_q;
        S_DFALL, S_OFALL: if (div_done) fall <= div_q;
        S_DDOWN: if (div_done) down <= div_q;
        S_DUP:   if (div_done) up <= div_q;
        S_TEST: begin
          if (fire) begin
            rem <= rising ? 35'(sum_bot) : 35'(sum_top);
            dur <= tick.trade_time - start_time;
            n   <= '0;
          end else begin
            vol_sum <= dced_pkg::sat_add(vol_sum, tick.trade_volume);
          end
        end
        S_MULEP, S_MULNX: begin
          prod       <= 65'(mul_price) * 65'(factor[32:0]);
          fac_nonpos <= factor <= 35'sd0;
        end
        S_SETEP: ep <= scaled;
        S_DMV, S_OMV: if (div_done) mv <= div_q;
        S_LOOP: begin
          // Clamp the far extreme to the event price before an overshoot record.
          if (loop_go) begin
            if (rising && (ep < max_p)) max_p <= ep;
            if (!rising && (ep > min_p)) min_p <= ep;
          end else begin
            vol_sum <= dced_pkg::sat_add(vol_sum, tick.trade_volume);
          end
        end
        S_EMITOS: begin
          if (emit_ok) begin
            out_valid <= 1'b1;
            out_data  <= '{event_time: tick.trade_time, event_price: ep,
                           high_price: max_p, low_price: min_p, event_move: mv,
                           top_excursion: top_cap, bottom_excursion: bot_cap,
                           duration: dur, event_volume: vol_sum,
                           trade_count: tick_cnt, last_of_run: 1'b0};
          end
        end
        S_SETNX: begin
          // Advance one overshoot step: next level becomes the new event price.
          start_p  <= ep;
          vol_sum  <= 32'd0;
          tick_cnt <= 32'd0;
          max_p    <= rising ? scaled : ep;
          min_p    <= rising ? ep : scaled;
          ep       <= scaled;
          dur      <= 48'd0;
          rem      <= rem - dl_s;
          n        <= n + 1'b1;
        end
        S_EMITFIN: begin
          if (emit_ok) begin
            out_valid  <= 1'b1;
            out_data   <= '{event_time: tick.trade_time, event_price: ep,
                            high_price: max_p, low_price: min_p, event_move: mv,
                            top_excursion: rise, bottom_excursion: fall,
                            duration: dur, event_volume: vol_sum,
                            trade_count: tick_cnt, last_of_run: 1'b1};
            start_time <= tick.trade_time;
            start_p    <= ep;
            max_p      <= ep;
            min_p      <= ep;
            vol_sum    <= 32'd0;
            tick_cnt   <= 32'd0;
            rise       <= 32'sd0;
            fall       <= 32'sd0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_launch_gap: assert property (@(posedge clk) disable iff (rst)
    launch |=> !launch) else $error("ratio launches back to back");
  a_accept_pre: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_PRE) else $error("accepted tick not started");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMITFIN && emit_ok) |=> state == S_IDLE && out_valid && out_data.last_of_run)
    else $error("final record not closing the tick");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for the directional-change event detector.
`timescale 1ns / 100ps

module tb;

  localparam longint unsigned MASK48    = 48'hFFFF_FFFF_FFFF;
  localparam longint          ONE_Q28   = 64'sd268435456;
  localparam int              DRAIN_CYC = 4000;
  localparam int              LIMIT_CYC = 10000000;

  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_stall;
  dced_pkg::in_t   in_data;
  logic            out_valid;
  logic            out_stall;
  dced_pkg::out_t  out_data;
  logic            cfg_we;
  logic [2:0]      cfg_index;
  logic [47:0]     cfg_data;

  directional_change_event_detector u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Ticks waiting to be offered, and event records the detector owes us.
  dced_pkg::in_t  tick_queue[$];
  dced_pkg::out_t pending_records[$];
  int   mismatch_count = 0;
  int   ticks_accepted = 0;
  int   cycle_count    = 0;

  // Shadow copy of the configuration registers.
  logic [27:0] m_delta;
  logic [31:0] m_vol_thr;
  logic [31:0] m_init_price;
  logic [47:0] m_win_start;
  logic [47:0] m_win_end;

  // Shadow copy of the event state.
  logic [31:0] m_filt, m_prior, m_buy_acc, m_sell_acc;
  logic [31:0] m_start, m_max, m_min;
  int          m_rise, m_fall;
  logic [47:0] m_start_time;
  logic [31:0] m_vol_sum, m_ticks;
  bit          m_past;

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Signed Q4.28 of (p - n) / d, truncated toward zero and saturated.
  function automatic int rel_move(logic [31:0] p, logic [31:0] n, logic [31:0] d);
    bit                neg;
    longint unsigned   mag;
    longint unsigned   q;
    neg = p < n;
    mag = neg ? 64'(n - p) : 64'(p - n);
    if (mag == 0) return 0;
    if (d == 0) return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    q = (mag << 28) / 64'(d);
    if (neg) return (q >= 64'h8000_0000) ? 32'sh8000_0000 : -int'(q);
    return (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : int'(q);
  endfunction

  // Price times a Q4.28 factor; a non-positive factor gives zero.
  function automatic logic [31:0] price_scale(logic [31:0] price, longint factor);
    longint unsigned v;
    if (factor <= 0) return 0;
    v = (64'(price) * longint'(factor)) >> 28;
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic void load_prices();
    m_filt  = m_init_price;
    m_prior = m_init_price;
    m_start = m_init_price;
    m_max   = m_init_price;
    m_min   = m_init_price;
  endfunction

  function automatic void push_record(logic [47:0] t, logic [31:0] ep, int mv, int top,
                                      int bot, logic [47:0] dur, bit last);
    dced_pkg::out_t r;
    r.event_time       = t;
    r.event_price      = ep;
    r.high_price       = m_max;
    r.low_price        = m_min;
    r.event_move       = mv;
    r.top_excursion    = top;
    r.bottom_excursion = bot;
    r.duration         = dur;
    r.event_volume     = m_vol_sum;
    r.trade_count      = m_ticks;
    r.last_of_run      = last;
    pending_records.push_back(r);
  endfunction

  // Advance the event state by one tick and queue the records it closes.
  function automatic void predict_events(dced_pkg::in_t tk);
    longint      dl, down, up, rem;
    bit          rising;
    logic [47:0] dur;
    logic [31:0] ep, nxt;
    int          mv, n;
    dl = longint'(m_delta);
    if (m_past || tk.trade_time < m_win_start) return;
    if (tk.trade_time > m_win_end) begin
      m_past = 1'b1;
      return;
    end
    if (tk.is_buy) begin
      m_buy_acc = add_sat(m_buy_acc, tk.trade_volume);
      if (m_buy_acc > m_vol_thr) begin
        m_buy_acc = 0;
        if (tk.trade_price < m_filt) m_filt = tk.trade_price;
      end
    end else begin
      m_sell_acc = add_sat(m_sell_acc, tk.trade_volume);
      if (m_sell_acc > m_vol_thr) begin
        m_sell_acc = 0;
        if (tk.trade_price > m_filt) m_filt = tk.trade_price;
      end
    end
    rising  = m_filt > m_prior;
    m_prior = m_filt;
    if (m_filt > m_max) begin
      m_max  = m_filt;
      m_rise = rel_move(m_max, m_start, m_start);
    end else if (m_filt < m_min) begin
      m_min  = m_filt;
      m_fall = rel_move(m_start, m_min, m_start);
    end
    down    = rel_move(m_max, m_filt, m_max);
    up      = rel_move(m_filt, m_min, m_min);
    m_ticks = add_sat(m_ticks, 1);
    if (longint'(m_rise) + down >= dl || longint'(m_fall) + up >= dl) begin
      dur = tk.trade_time - m_start_time;
      n   = 0;
      if (rising) begin
        rem = longint'(m_fall) + up;
        ep  = price_scale(m_min, ONE_Q28 + dl - longint'(m_fall));
      end else begin
        rem = longint'(m_rise) + down;
        ep  = price_scale(m_max, ONE_Q28 - dl + longint'(m_rise));
      end
      mv = rel_move(m_start, ep, m_start);
      // Overshoot records, bounded so that the final record always fits.
      while (rem >= 2 * dl && n < dced_pkg::MAX_RECORDS - 1) begin
        if (rising) begin
          if (ep < m_max) m_max = ep;
        end else begin
          if (ep > m_min) m_min = ep;
        end
        push_record(tk.trade_time, ep, mv,
                    (longint'(m_rise) < dl) ? m_rise : int'(dl),
                    (longint'(m_fall) < dl) ? m_fall : int'(dl), dur, 1'b0);
        n++;
        nxt       = price_scale(ep, rising ? ONE_Q28 + dl : ONE_Q28 - dl);
        m_start   = ep;
        m_vol_sum = 0;
        m_ticks   = 0;
        if (rising) begin
          m_max = nxt;
          m_min = ep;
        end else begin
          m_max = ep;
          m_min = nxt;
        end
        m_rise = rel_move(m_max, m_start, m_start);
        m_fall = rel_move(m_start, m_min, m_start);
        mv     = rel_move(m_start, nxt, m_start);
        ep     = nxt;
        dur    = 0;
        rem    = rem - dl;
      end
      m_vol_sum = add_sat(m_vol_sum, tk.trade_volume);
      push_record(tk.trade_time, ep, mv, m_rise, m_fall, dur, 1'b1);
      m_start_time = tk.trade_time;
      m_start      = ep;
      m_max        = ep;
      m_min        = ep;
      m_vol_sum    = 0;
      m_ticks      = 0;
      m_rise       = 0;
      m_fall       = 0;
      return;
    end
    m_vol_sum = add_sat(m_vol_sum, tk.trade_volume);
  endfunction

  // Driver: offer queued ticks, hold a stalled transaction, idle now and then.
  // Stay busy without gaps through a stretch in the middle of the run.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_events(in_data);
        ticks_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (tick_queue.size() > 0 &&
            ((ticks_accepted > 200 && ticks_accepted < 250) ||
             $urandom_range(0, 99) >= 6)) begin
          in_valid <= 1'b1;
          in_data  <= tick_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string fname, longint unsigned want, longint unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch %s: expected %0h, got %0h", fname, want, got);
    end
  endtask

  // Monitor: compare each record transaction with the oldest prediction.
  always @(posedge clk) begin
    dced_pkg::out_t want;
    cycle_count++;
    if (cycle_count > LIMIT_CYC) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end else if (!rst && out_valid && !out_stall) begin
      if (pending_records.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected record: %p", out_data);
      end else begin
        want = pending_records.pop_front();
        check_field("event_time",       want.event_time,       out_data.event_time);
        check_field("event_price",      want.event_price,      out_data.event_price);
        check_field("high_price",       want.high_price,       out_data.high_price);
        check_field("low_price",        want.low_price,        out_data.low_price);
        check_field("event_move",       32'(want.event_move),  32'(out_data.event_move));
        check_field("top_excursion",    32'(want.top_excursion),
                    32'(out_data.top_excursion));
        check_field("bottom_excursion", 32'(want.bottom_excursion),
                    32'(out_data.bottom_excursion));
        check_field("duration",         want.duration,         out_data.duration);
        check_field("event_volume",     want.event_volume,     out_data.event_volume);
        check_field("trade_count",      want.trade_count,      out_data.trade_count);
        check_field("last_of_run",      want.last_of_run,      out_data.last_of_run);
      end
    end
  end

  // Receiver stall: one long hold-off so the block backs up onto its input,
  // a quiet stretch, and random stalls elsewhere.
  int hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && ticks_accepted >= 150) begin
      hold_done = 1;
      hold_left = 3000;
      out_stall <= 1'b1;
    end else if (ticks_accepted > 60 && ticks_accepted < 110) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 6);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      dced_pkg::REG_EVENT_THRESHOLD:  m_delta = val[27:0];
      dced_pkg::REG_VOLUME_THRESHOLD: m_vol_thr = val[31:0];
      dced_pkg::REG_INITIAL_PRICE: begin
        m_init_price = val[31:0];
        load_prices();
      end
      dced_pkg::REG_INITIAL_TIME:     m_start_time = val;
      dced_pkg::REG_WINDOW_START:     m_win_start = val;
      dced_pkg::REG_WINDOW_END:       m_win_end = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every tick is in and every record is out, then let the last
  // quiet tick finish its divisions.
  task automatic drain();
    while (tick_queue.size() > 0 || in_valid || pending_records.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  function automatic void add_tick(logic [31:0] p, logic [31:0] v, bit b, logic [47:0] t);
    dced_pkg::in_t tk;
    tk.trade_price  = p;
    tk.trade_volume = v;
    tk.is_buy       = b;
    tk.trade_time   = t;
    tick_queue.push_back(tk);
  endfunction

  // Random walk around a level, volume mostly between half and one and a half thresholds.
  task automatic add_walk(int count, logic [31:0] level, logic [47:0] t0, int full_pct);
    logic [31:0] walk, step, vol;
    logic [47:0] t;
    walk = level;
    t    = t0;
    repeat (count) begin
      step = (walk >> 6) + 1;
      if ($urandom_range(0, 1)) walk = walk + $urandom_range(0, 32'(step));
      else if (walk > step) walk = walk - $urandom_range(0, 32'(step));
      case ($urandom_range(0, 9))
        0:       vol = $urandom();
        1:       vol = 0;
        default: vol = (m_vol_thr >> 1) + $urandom_range(0, 32'(m_vol_thr));
      endcase
      t = t + $urandom_range(0, 2000);
      if ($urandom_range(0, 99) < full_pct)
        add_tick($urandom(), $urandom(), $urandom_range(0, 1),
                 {16'($urandom()), 32'($urandom())});
      else
        add_tick((walk == 0) ? 32'd1 : walk, vol, $urandom_range(0, 1), t);
    end
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = dced_pkg::REG_EVENT_THRESHOLD;
    cfg_data  = '0;
    m_delta      = 28'd2684355;
    m_vol_thr    = 32'd2560;
    m_init_price = 32'd256;
    m_win_start  = 0;
    m_win_end    = MASK48;
    load_prices();
    m_buy_acc    = 0;
    m_sell_acc   = 0;
    m_rise       = 0;
    m_fall       = 0;
    m_start_time = 0;
    m_vol_sum    = 0;
    m_ticks      = 0;
    m_past       = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: field extremes, both sides, time going backwards.
    add_tick(32'd300,         32'd3000,      1'b0, 48'd10);
    add_tick(32'd200,         32'd3000,      1'b1, 48'd20);
    add_tick(32'd1,           32'hFFFF_FFFF, 1'b1, 48'd30);
    add_tick(32'hFFFF_FFFF,   32'hFFFF_FFFF, 1'b0, 48'd40);
    add_tick(32'd500,         32'd0,         1'b0, 48'd0);
    add_tick(32'd1,           32'd2561,      1'b1, MASK48);
    add_tick(32'd100,         32'd2560,      1'b1, 48'd5);
    add_tick(32'd400,         32'd2561,      1'b0, 48'h5555_5555_5555);
    add_tick(32'h8000_0000,   32'd9000,      1'b0, 48'hAAAA_AAAA_AAAA);
    add_tick(32'd256,         32'd9000,      1'b1, 48'd3);
    add_tick(32'hFFFF_FFFF,   32'hFFFF_FFFF, 1'b0, 48'd50);
    add_tick(32'hFFFF_FFFF,   32'hFFFF_FFFF, 1'b0, 48'd60);
    add_tick(32'd1,           32'hFFFF_FFFF, 1'b1, 48'd70);
    add_walk(100, 32'd25600, 48'd100, 5);
    drain();

    // No threshold at all: every tick closes with the full overshoot run.
    write_reg(dced_pkg::REG_EVENT_THRESHOLD, 48'd0);
    write_reg(dced_pkg::REG_VOLUME_THRESHOLD, 48'd0);
    write_reg(dced_pkg::REG_INITIAL_PRICE, 48'd1);
    add_tick(32'd2, 32'd1, 1'b0, 48'd1);
    add_walk(12, 32'd1000, 48'd10, 10);
    drain();

    // Largest thresholds, prices and start time; narrow window at the top.
    write_reg(dced_pkg::REG_EVENT_THRESHOLD, 48'hFFF_FFFF);
    write_reg(dced_pkg::REG_VOLUME_THRESHOLD, 48'hFFFF_FFFF);
    write_reg(dced_pkg::REG_INITIAL_PRICE, 48'hFFFF_FFFF);
    write_reg(dced_pkg::REG_INITIAL_TIME, MASK48);
    add_walk(15, 32'hF000_0000, 48'd0, 40);
    drain();
    write_reg(dced_pkg::REG_WINDOW_START, MASK48);
    add_tick(32'd1, 32'hFFFF_FFFF, 1'b1, MASK48);
    add_tick(32'd5, 32'd7, 1'b0, MASK48 - 1);
    drain();

    // Mid settings, then a tick past the window end closes the stream.
    write_reg(dced_pkg::REG_EVENT_THRESHOLD, 48'h100_0000);
    write_reg(dced_pkg::REG_VOLUME_THRESHOLD, 48'd256);
    write_reg(dced_pkg::REG_INITIAL_PRICE, 48'd25600);
    write_reg(dced_pkg::REG_INITIAL_TIME, 48'd1000);
    write_reg(dced_pkg::REG_WINDOW_START, 48'd500);
    write_reg(dced_pkg::REG_WINDOW_END, 48'h8000_0000_0000);
    add_tick(32'd25000, 32'd300, 1'b1, 48'd499);
    add_walk(150, 32'd25600, 48'd400, 3);
    add_tick(32'd20000, 32'd300, 1'b1, 48'h8000_0000_0001);
    add_tick(32'd30000, 32'd300, 1'b0, 48'd600);
    drain();

    if (mismatch_count == 0 && pending_records.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
